// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files of the PID core.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define PTC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define PTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/pid_tc_pkg.sv -----
// Package of the trapezoidal PID core: types, constants and saturation helpers.
// Used by pid_tc_div and pid_trapezoid_clamped_core; depends on nothing.
package pid_tc_pkg;

   // fixed-point format default and data widths
   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int GAIN_W        = 31;
   localparam int PROD_W        = 65;
   localparam int MAG_W         = 63;
   localparam int CSR_IDX_W     = 4;

   // divider: two quotient bits per step
   localparam int QUOT_W        = 32;
   localparam int DIV_STEPS     = QUOT_W / 2;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P        = 4'd0,
      REG_GAIN_I        = 4'd1,
      REG_GAIN_D        = 4'd2,
      REG_SAMPLE_PERIOD = 4'd3,
      REG_INTEG_UPPER   = 4'd4,
      REG_INTEG_LOWER   = 4'd5,
      REG_DRIVE_UPPER   = 4'd6,
      REG_DRIVE_LOWER   = 4'd7
   } csr_reg_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_K,
      ST_KDT,
      ST_MUL_I,
      ST_MUL_D,
      ST_DIV_PREP,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SUM,
      ST_DONE
   } state_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic done;
      logic ovf;
   } div_status_type;

   // saturate a wide signed value to 32 bits
   function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W-1:0] max_v;
      logic signed [PROD_W-1:0] min_v;
      max_v = {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
      min_v = {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
      if (x > max_v)
         return max_v[DATA_W-1:0];
      else if (x < min_v)
         return min_v[DATA_W-1:0];
      else
         return x[DATA_W-1:0];
   endfunction

   // upper limit tested first, then lower
   function automatic logic signed [DATA_W-1:0] clamp_s32(input logic signed [PROD_W-1:0] x,
                                                         input logic signed [DATA_W-1:0] lo,
                                                         input logic signed [DATA_W-1:0] hi);
      logic signed [PROD_W-1:0] lo_w;
      logic signed [PROD_W-1:0] hi_w;
      lo_w = {{(PROD_W-DATA_W){lo[DATA_W-1]}}, lo};
      hi_w = {{(PROD_W-DATA_W){hi[DATA_W-1]}}, hi};
      if (x > hi_w)
         return hi;
      else if (x < lo_w)
         return lo;
      else
         return x[DATA_W-1:0];
   endfunction

endpackage

// ----- rtl/core/pid_trapezoid_clamped_core.sv -----
// PID controller, trapezoidal integral, clamped integrator and output.
// Depends on pid_tc_pkg and pid_tc_div; one shared 32x33 multiplier.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_target, req_measured
//   rsp      out        rsp_valid/rsp_stall  rsp_drive
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A transaction makes four passes through the shared multiplier, then runs the
// radix-4 divider (16 steps) for the derivative term; the steps are skipped when
// its quotient saturates (zero time step included).
// req_stall is high while a transaction is in work; the result register lets
// a new transaction start while the previous result waits on rsp_stall, and a
// finished one waits while it is full.
// Synchronous reset clears the sequencer and the state and sets the config registers to their defaults.
module pid_trapezoid_clamped_core #(
   parameter int FRAC_BITS = pid_tc_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [pid_tc_pkg::DATA_W-1:0] req_target,
   input  logic signed [pid_tc_pkg::DATA_W-1:0] req_measured,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [pid_tc_pkg::DATA_W-1:0] rsp_drive,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pid_tc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pid_tc_pkg::DATA_W-1:0]        csr_wdata
);

   localparam int DW = pid_tc_pkg::DATA_W;
   localparam int GW = pid_tc_pkg::GAIN_W;
   localparam int PW = pid_tc_pkg::PROD_W;
   localparam int MW = pid_tc_pkg::MAG_W;

   // configuration registers
   logic [GW-1:0]        gain_p_ff, gain_i_ff, gain_d_ff, period_ff;
   logic signed [DW-1:0] integ_upper_ff, integ_lower_ff;
   logic signed [DW-1:0] drive_upper_ff, drive_lower_ff;

   // sequencer and datapath registers
   pid_tc_pkg::state_type  state_ff, state_in;
   logic signed [DW-1:0]   err_ff, err_in;
   logic signed [DW:0]     sum_ff, sum_in;
   logic signed [DW:0]     diff_ff, diff_in;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic signed [DW-1:0]   prop_ff, prop_in;
   logic [GW-1:0]          kdt_ff, kdt_in;
   logic signed [PW-1:0]   integ_raw_ff, integ_raw_in;
   logic signed [DW-1:0]   integ_acc_ff, integ_acc_in;
   logic signed [DW-1:0]   last_error_ff, last_error_in;
   logic [MW-1:0]          num_mag_ff, num_mag_in;
   logic                   num_neg_ff, num_neg_in;
   logic                   num_zero_ff, num_zero_in;
   logic signed [DW-1:0]   deriv_ff, deriv_in;
   logic signed [DW-1:0]   total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]   rsp_drive_ff, rsp_drive_in;

   // shared multiplier operands
   logic signed [DW-1:0]   mul_a;
   logic signed [DW:0]     mul_b;

   // divider hookup
   logic                          div_start;
   pid_tc_pkg::div_status_type    div_status;
   logic [pid_tc_pkg::QUOT_W-1:0] div_quot;

   // helpers
   logic                   req_accept;
   logic signed [DW:0]     req_diff;
   logic signed [PW-1:0]   prod_abs;
   logic signed [DW+1:0]   total_sum;
   logic signed [PW-1:0]   sh_f, sh_f1;
   logic signed [DW-1:0]   q_signed;
   logic signed [DW-1:0]   sat_max, sat_min;
   logic                   rsp_load;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != pid_tc_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_drive  = rsp_drive_ff;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= '0;
         gain_i_ff      <= '0;
         gain_d_ff      <= '0;
         period_ff      <= GW'(655);
         integ_upper_ff <= {1'b0, {(DW-1){1'b1}}};
         integ_lower_ff <= {1'b1, {(DW-1){1'b0}}};
         drive_upper_ff <= {1'b0, {(DW-1){1'b1}}};
         drive_lower_ff <= {1'b1, {(DW-1){1'b0}}};
      end else if (csr_valid && csr_ready) begin
         unique case (pid_tc_pkg::csr_reg_type'(csr_index))
            pid_tc_pkg::REG_GAIN_P:        gain_p_ff      <= csr_wdata[GW-1:0];
            pid_tc_pkg::REG_GAIN_I:        gain_i_ff      <= csr_wdata[GW-1:0];
            pid_tc_pkg::REG_GAIN_D:        gain_d_ff      <= csr_wdata[GW-1:0];
            pid_tc_pkg::REG_SAMPLE_PERIOD: period_ff      <= csr_wdata[GW-1:0];
            pid_tc_pkg::REG_INTEG_UPPER:   integ_upper_ff <= csr_wdata;
            pid_tc_pkg::REG_INTEG_LOWER:   integ_lower_ff <= csr_wdata;
            pid_tc_pkg::REG_DRIVE_UPPER:   drive_upper_ff <= csr_wdata;
            pid_tc_pkg::REG_DRIVE_LOWER:   drive_lower_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // fixed datapath pieces around the shared multiplier
   always_comb begin
      req_diff  = {req_target[DW-1], req_target} - {req_measured[DW-1], req_measured};
      sh_f      = prod_ff >>> FRAC_BITS;
      sh_f1     = prod_ff >>> (FRAC_BITS + 1);
      prod_abs  = prod_ff[PW-1] ? -prod_ff : prod_ff;
      total_sum = {{2{prop_ff[DW-1]}}, prop_ff} + {{2{integ_acc_ff[DW-1]}}, integ_acc_ff}
                + {{2{deriv_ff[DW-1]}}, deriv_ff};
      q_signed  = num_neg_ff ? -$signed(div_quot) : $signed(div_quot);
      sat_max   = {1'b0, {(DW-1){1'b1}}};
      sat_min   = {1'b1, {(DW-1){1'b0}}};
      rsp_load  = (state_ff == pid_tc_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   // shared multiplier, registered
   assign prod_in = mul_a * mul_b;

   // sequencer: next state, operand select, register updates
   always_comb begin
      state_in      = state_ff;
      err_in        = err_ff;
      sum_in        = sum_ff;
      diff_in       = diff_ff;
      prop_in       = prop_ff;
      kdt_in        = kdt_ff;
      integ_raw_in  = integ_raw_ff;
      integ_acc_in  = integ_acc_ff;
      last_error_in = last_error_ff;
      num_mag_in    = num_mag_ff;
      num_neg_in    = num_neg_ff;
      num_zero_in   = num_zero_ff;
      deriv_in      = deriv_ff;
      total_in      = total_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_start     = 1'b0;
      rsp_drive_in  = rsp_drive_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         pid_tc_pkg::ST_IDLE: begin
            if (req_accept) begin
               err_in   = pid_tc_pkg::sat_s32({{(PW-DW-1){req_diff[DW]}}, req_diff});
               state_in = pid_tc_pkg::ST_MUL_P;
            end
         end
         pid_tc_pkg::ST_MUL_P: begin
            mul_a    = {1'b0, gain_p_ff};
            mul_b    = {err_ff[DW-1], err_ff};
            sum_in   = {err_ff[DW-1], err_ff} + {last_error_ff[DW-1], last_error_ff};
            diff_in  = {err_ff[DW-1], err_ff} - {last_error_ff[DW-1], last_error_ff};
            state_in = pid_tc_pkg::ST_MUL_K;
         end
         pid_tc_pkg::ST_MUL_K: begin
            prop_in  = pid_tc_pkg::sat_s32(sh_f);
            mul_a    = {1'b0, gain_i_ff};
            mul_b    = {2'b00, period_ff};
            state_in = pid_tc_pkg::ST_KDT;
         end
         pid_tc_pkg::ST_KDT: begin
            // nonnegative product, so saturation caps at 2^31-1
            kdt_in   = GW'(pid_tc_pkg::sat_s32(sh_f));
            state_in = pid_tc_pkg::ST_MUL_I;
         end
         pid_tc_pkg::ST_MUL_I: begin
            mul_a    = {1'b0, kdt_ff};
            mul_b    = sum_ff;
            state_in = pid_tc_pkg::ST_MUL_D;
         end
         pid_tc_pkg::ST_MUL_D: begin
            integ_raw_in = {{(PW-DW){integ_acc_ff[DW-1]}}, integ_acc_ff} + sh_f1;
            mul_a        = {1'b0, gain_d_ff};
            mul_b        = diff_ff;
            state_in     = pid_tc_pkg::ST_DIV_PREP;
         end
         pid_tc_pkg::ST_DIV_PREP: begin
            integ_acc_in = pid_tc_pkg::clamp_s32(integ_raw_ff, integ_lower_ff, integ_upper_ff);
            num_neg_in   = prod_ff[PW-1];
            num_zero_in  = (prod_ff == '0);
            num_mag_in   = prod_abs[MW-1:0];
            state_in     = pid_tc_pkg::ST_DIV_START;
         end
         pid_tc_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = pid_tc_pkg::ST_DIV_WAIT;
         end
         pid_tc_pkg::ST_DIV_WAIT: begin
            if (div_status.done) begin
               if (num_zero_ff)
                  deriv_in = '0;
               else if (div_status.ovf)
                  deriv_in = num_neg_ff ? sat_min : sat_max;
               else
                  deriv_in = q_signed;
               state_in = pid_tc_pkg::ST_SUM;
            end
         end
         pid_tc_pkg::ST_SUM: begin
            total_in = pid_tc_pkg::sat_s32({{(PW-DW-2){total_sum[DW+1]}}, total_sum});
            state_in = pid_tc_pkg::ST_DONE;
         end
         pid_tc_pkg::ST_DONE: begin
            // hold until the result register is free
            if (rsp_load) begin
               rsp_drive_in  = pid_tc_pkg::clamp_s32({{(PW-DW){total_ff[DW-1]}}, total_ff},
                                                     drive_lower_ff, drive_upper_ff);
               rsp_valid_in  = 1'b1;
               last_error_in = err_ff;
               state_in      = pid_tc_pkg::ST_IDLE;
            end
         end
         default: state_in = pid_tc_pkg::ST_IDLE;
      endcase
   end

   // control state and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pid_tc_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         integ_acc_ff  <= '0;
         last_error_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         integ_acc_ff  <= integ_acc_in;
         last_error_ff <= last_error_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      sum_ff       <= sum_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      prop_ff      <= prop_in;
      kdt_ff       <= kdt_in;
      integ_raw_ff <= integ_raw_in;
      num_mag_ff   <= num_mag_in;
      num_neg_ff   <= num_neg_in;
      num_zero_ff  <= num_zero_in;
      deriv_ff     <= deriv_in;
      total_ff     <= total_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   // derivative divider
   pid_tc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_mag_ff),
      .divisor  (period_ff),
      .status   (div_status),
      .quot     (div_quot)
   );

endmodule

// ----- rtl/core/pid_tc_div.sv -----
// Radix-4 restoring divider for the derivative term, with overflow detect.
// Depends on pid_tc_pkg; quotient magnitude fits 31 bits when no overflow.
module pid_tc_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [pid_tc_pkg::MAG_W-1:0]           dividend,
   input  logic [pid_tc_pkg::GAIN_W-1:0]          divisor,
   output pid_tc_pkg::div_status_type             status,
   output logic [pid_tc_pkg::QUOT_W-1:0]          quot
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic                                 ovf_ff, ovf_in;
   logic [pid_tc_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [pid_tc_pkg::GAIN_W-1:0]        rem_ff, rem_in;
   logic [pid_tc_pkg::QUOT_W-1:0]        quo_ff, quo_in;

   logic [pid_tc_pkg::GAIN_W:0]          dvs_w;
   logic [pid_tc_pkg::GAIN_W:0]          t1, t2, s1, s2;
   logic                                 ge1, ge2;
   logic [pid_tc_pkg::GAIN_W-1:0]        r1, r2;
   logic                                 big;

   // two compare-subtract steps per cycle
   always_comb begin
      dvs_w = {1'b0, divisor};
      t1    = {rem_ff, quo_ff[pid_tc_pkg::QUOT_W-1]};
      ge1   = (t1 >= dvs_w);
      s1    = t1 - dvs_w;
      r1    = ge1 ? s1[pid_tc_pkg::GAIN_W-1:0] : t1[pid_tc_pkg::GAIN_W-1:0];
      t2    = {r1, quo_ff[pid_tc_pkg::QUOT_W-2]};
      ge2   = (t2 >= dvs_w);
      s2    = t2 - dvs_w;
      r2    = ge2 ? s2[pid_tc_pkg::GAIN_W-1:0] : t2[pid_tc_pkg::GAIN_W-1:0];
      // quotient would need 32 or more bits
      big   = (dividend[pid_tc_pkg::MAG_W-1:pid_tc_pkg::GAIN_W] >= dvs_w);
   end

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         ovf_in = big;
         if (big) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            rem_in  = dividend[pid_tc_pkg::MAG_W-1:pid_tc_pkg::QUOT_W];
            quo_in  = dividend[pid_tc_pkg::QUOT_W-1:0];
         end
      end else if (busy_ff) begin
         rem_in = r2;
         quo_in = {quo_ff[pid_tc_pkg::QUOT_W-3:0], ge1, ge2};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == pid_tc_pkg::DIV_CNT_W'(pid_tc_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ovf_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         ovf_ff  <= ovf_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.done = done_ff;
   assign status.ovf  = ovf_ff;
   assign quot        = quo_ff;

endmodule

// ----- rtl/core/pid_tc_checker.sv -----
// Port-level checks of the PID core, attached by the bind at the end.
// Depends on pid_tc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pid_tc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [pid_tc_pkg::DATA_W-1:0]    rsp_drive,
   input logic                             csr_valid,
   input logic                             csr_ready
);

   // a stalled response holds its payload
   `PTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_drive), "rsp payload changed while stalled")

   // an accepted transaction makes the core busy
   `PTC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "req not stalled after acceptance")

   // a result never follows acceptance in the next cycle
   `PTC_ASSERT_NEXT(a_min_latency, clock, reset, req_valid && !req_stall, !$rose(rsp_valid), "result appeared one cycle after acceptance")

   // a new result only comes out of a transaction in work
   `PTC_ASSERT(a_rsp_from_work, clock, reset, !$rose(rsp_valid) || $past(req_stall), "result rose with no transaction in work")

   // configuration writes are never refused
   `PTC_ASSERT(a_csr_ready, clock, reset, !csr_valid || csr_ready, "csr write refused")

endmodule

bind pid_trapezoid_clamped_core pid_tc_checker u_pid_tc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_drive (rsp_drive),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
